### hw/rtl/tspd_pkg.sv
// ----------------------------------------------------------------------------
// tspd_pkg: shared constants for the thermal segment packet deframer
// Packet geometry, header layout and output packing widths.
// ----------------------------------------------------------------------------
package tspd_pkg;

	localparam int PACKET_BYTES        = 164;
	localparam int PACKETS_PER_SEGMENT = 60;
	localparam int PIXELS_PER_PACKET   = 80;
	localparam int SEGMENTS            = 4;

	localparam int HDR_BYTES     = 4;
	localparam int SELECT_PACKET = 20;

	localparam logic [3:0] ID_DISCARD_NIBBLE = 4'hF;

	localparam int SEG_SPAN = PACKETS_PER_SEGMENT * PIXELS_PER_PACKET;

	localparam int POS_W     = 8;
	localparam int PNUM_W    = 6;
	localparam int SEG_W     = 3;
	localparam int PIX_W     = 7;
	localparam int IDX_W     = 15;
	localparam int IDX_SUM_W = 17;
	localparam int VAL_W     = 16;
	localparam int DISC_W    = 16;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 48;

endpackage

### hw/rtl/thermal_segment_packet_deframer.sv
// ----------------------------------------------------------------------------
// thermal_segment_packet_deframer
// Reassembles camera video packets into indexed pixel words.
// ----------------------------------------------------------------------------
// One stream byte is taken per transaction and may follow in every cycle. A
// byte is held in the input register, where the packet header is decoded
// and the pixel index is formed from the segment, packet number and pixel
// position, then moves into the result register once the result side can
// take it; the sustained rate is one byte per cycle while the result side
// keeps up. s_tuser marks the first byte of a packet. m_tlast is high on the
// last pixel of the last segment.
module thermal_segment_packet_deframer
	import tspd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [7:0] stream_byte
	input  logic                  s_tuser,  // [0] packet_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [14:0] pixel_index, [30:15] pixel_value, [46:31] discard_total, [47] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast   // frame_done
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;

	logic [POS_W-1:0]     pos_q;
	logic [7:0]           id_q;
	logic [PNUM_W-1:0]    pnum_q;
	logic                 drop_q;
	logic [SEG_W-1:0]     seg_q;
	logic [7:0]           low_q;
	logic [DISC_W-1:0]    disc_q;

	logic                 out_valid_q;
	logic [IDX_W-1:0]     idx_q;
	logic [VAL_W-1:0]     val_q;
	logic [DISC_W-1:0]    disc_out_q;
	logic                 done_q;

	logic                 out_ready;
	logic                 fire_s1;

	logic [POS_W-1:0]     pos;
	logic [POS_W:0]       pos_inc;
	logic [POS_W-1:0]     pos_next;
	logic [POS_W-1:0]     off;
	logic [PIX_W:0]       pix;
	logic [SEG_W-1:0]     sel;
	logic [SEG_W-1:0]     seg_m1;
	logic [IDX_SUM_W-1:0] idx_sum;
	logic                 res_valid;
	logic                 last_pix;
	logic                 done;
	logic [7:0]           id_next;
	logic [PNUM_W-1:0]    pnum_next;
	logic                 drop_next;
	logic [SEG_W-1:0]     seg_next;
	logic [7:0]           low_next;
	logic [DISC_W-1:0]    disc_next;

	assign out_ready = !out_valid_q || m_tready;
	assign fire_s1   = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_comb begin
		pos = start_s1 ? '0 : pos_q;
		if (32'(pos) >= PACKET_BYTES) begin
			pos = '0;
		end
		pos_inc  = {1'b0, pos} + (POS_W+1)'(1);
		pos_next = (32'(pos_inc) >= PACKET_BYTES) ? '0 : pos_inc[POS_W-1:0];

		off    = pos - POS_W'(HDR_BYTES);
		pix    = {1'b0, off[POS_W-1:1]};
		sel    = id_q[6:4];
		seg_m1 = seg_q - SEG_W'(1);

		id_next   = id_q;
		pnum_next = pnum_q;
		drop_next = drop_q;
		seg_next  = seg_q;
		low_next  = low_q;
		disc_next = disc_q;
		res_valid = 1'b0;

		last_pix = (32'(pnum_q) == PACKETS_PER_SEGMENT - 1) &&
			(32'(pix) == PIXELS_PER_PACKET - 1);
		done     = last_pix && (32'(seg_q) >= SEGMENTS);
		idx_sum  = IDX_SUM_W'(seg_m1) * IDX_SUM_W'(SEG_SPAN) +
			IDX_SUM_W'(pnum_q) * IDX_SUM_W'(PIXELS_PER_PACKET) + IDX_SUM_W'(pix);

		if (pos == '0) begin
			id_next   = byte_s1;
			drop_next = 1'b0;
		end else if (pos == POS_W'(1)) begin
			if (id_q[3:0] == ID_DISCARD_NIBBLE || 32'(byte_s1) >= PACKETS_PER_SEGMENT) begin
				drop_next = 1'b1;
				if (disc_q != '1) begin
					disc_next = disc_q + DISC_W'(1);
				end
			end else begin
				drop_next = 1'b0;
				pnum_next = byte_s1[PNUM_W-1:0];
				if (32'(byte_s1) == SELECT_PACKET && sel != '0 && 32'(sel) <= SEGMENTS) begin
					seg_next = sel;
				end
			end
		end else if (32'(pos) >= HDR_BYTES && 32'(pix) < PIXELS_PER_PACKET) begin
			if (!off[0]) begin
				low_next = byte_s1;
			end else if (!drop_q && seg_q != '0) begin
				res_valid = 1'b1;
				if (done) begin
					seg_next  = '0;
					disc_next = '0;
				end else if (last_pix) begin
					seg_next = seg_q + SEG_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			id_q   <= '0;
			pnum_q <= '0;
			drop_q <= 1'b0;
			seg_q  <= '0;
			low_q  <= '0;
			disc_q <= '0;
		end else if (fire_s1) begin
			pos_q  <= pos_next;
			id_q   <= id_next;
			pnum_q <= pnum_next;
			drop_q <= drop_next;
			seg_q  <= seg_next;
			low_q  <= low_next;
			disc_q <= disc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_valid) begin
			idx_q      <= idx_sum[IDX_W-1:0];
			val_q      <= {byte_s1, low_q};
			disc_out_q <= disc_q;
			done_q     <= done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, disc_out_q, val_q, idx_q};
	assign m_tlast  = done_q;

	// The segment never leaves the range of configured segments.
	assert property (@(posedge clk) disable iff (!arst_n) 32'(seg_q) <= SEGMENTS)
		else $error("segment out of range");

	// The end of a frame always falls on the final pixel position.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> 32'(m_tdata[IDX_W-1:0]) ==
			((SEGMENTS * SEG_SPAN - 1) % (1 << IDX_W)))
		else $error("frame end at wrong pixel index");

	// Finishing a frame clears the segment and the discard count.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && res_valid && done |=> seg_q == '0 && disc_q == '0)
		else $error("frame end did not clear state");

	// An empty result register never holds off the input side.
	assert property (@(posedge clk) disable iff (!arst_n) !out_valid_q |-> s_tready)
		else $error("input stalled with empty result register");

endmodule
